/* rtl/core/grid_wavefront_distance_transform_macros.svh */
// Assertion macros for the grid wavefront distance transform block.
// Include this header before any module that asserts; it needs no other file.
`ifndef GRID_WAVEFRONT_DISTANCE_TRANSFORM_MACROS_SVH
`define GRID_WAVEFRONT_DISTANCE_TRANSFORM_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, disabled while reset is low.
`define GWDT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gwdt check failed");
// Next-cycle implication, disabled while reset is low.
`define GWDT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gwdt check failed");
`else
`define GWDT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define GWDT_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/core/gwdt_pkg.sv */
// Shared types and constants of the grid wavefront distance transform.
// No dependencies; every other file but the macros header uses it.
package gwdt_pkg;

    localparam int MODE_W     = 2;
    localparam int ROW_W      = 6;
    localparam int COL_W      = 6;
    localparam int VALUE_W    = 8;
    localparam int LABEL_W    = 8;
    localparam int EMPTY_W    = 13;
    localparam int LEVEL_W    = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int GRID_DIM_W = 7;

    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RUN   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_METRIC = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS   = 2'd3;

    // Flags that travel with each streamed grid element.
    typedef struct packed {
        logic real_cell;  // element comes from the store
        logic ins;        // element lies inside the grid in use
        logic first;      // column zero
        logic last;       // last column in use
    } t_tag;

    // Verdict on the center element of the window.
    typedef struct packed {
        logic real_cell;
        logic fill;       // empty and touched by the wavefront
        logic empty;      // empty and stays empty
    } t_cen;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_READ  = 4'b0010,
        S_RUN   = 4'b0100,
        S_DRAIN = 4'b1000
    } t_state;

endpackage

/* rtl/core/gwdt_in_if.sv */
// Input channel of the grid wavefront distance transform.
// Depends on gwdt_pkg for field widths.
interface gwdt_in_if;
    logic                            valid;
    logic                            ready;
    logic [gwdt_pkg::MODE_W-1:0]     mode;
    logic [gwdt_pkg::ROW_W-1:0]      row;
    logic [gwdt_pkg::COL_W-1:0]      col;
    logic [gwdt_pkg::VALUE_W-1:0]    cell_value;

    modport source (output valid, mode, row, col, cell_value, input ready);
    modport sink   (input valid, mode, row, col, cell_value, output ready);
endinterface

/* rtl/core/gwdt_out_if.sv */
// Result channel of the grid wavefront distance transform.
// Depends on gwdt_pkg for field widths.
interface gwdt_out_if;
    logic                            valid;
    logic                            ready;
    logic [gwdt_pkg::LABEL_W-1:0]    cell_label;
    logic [gwdt_pkg::EMPTY_W-1:0]    empty_left;

    modport source (output valid, cell_label, empty_left, input ready);
    modport sink   (input valid, cell_label, empty_left, output ready);
endinterface

/* rtl/core/gwdt_cell.sv */
// One element slot of the streaming window chain.
// Depends on gwdt_pkg.
module gwdt_cell #(
    parameter int LB = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_clr,
    input  logic            i_shift,
    input  logic [LB-1:0]   i_lab,
    input  gwdt_pkg::t_tag  i_tag,
    output logic [LB-1:0]   o_lab,
    output gwdt_pkg::t_tag  o_tag
);
    import gwdt_pkg::*;

    logic [LB-1:0] r_lab;
    t_tag          r_tag;

    // Flags clear on reset and at each pass start; the label is payload.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_tag <= '0;
        end else if (i_shift) begin
            r_tag <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_lab <= i_lab;
        end
    end

    assign o_lab = r_lab;
    assign o_tag = r_tag;
endmodule

/* rtl/core/gwdt_chain.sv */
// Two grid rows plus three elements of cells forming a sliding 3x3 window.
// Depends on gwdt_pkg and gwdt_cell.
module gwdt_chain #(
    parameter int MAX_COLS = 64,
    parameter int LB       = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_clr,
    input  logic                          i_shift,
    input  logic [LB-1:0]                 i_lab,
    input  gwdt_pkg::t_tag                i_tag,
    input  logic [gwdt_pkg::LEVEL_W-1:0]  i_level,
    input  logic                          i_metric,
    output gwdt_pkg::t_cen                o_cen
);
    import gwdt_pkg::*;

    localparam int NC   = 2 * MAX_COLS + 3;
    localparam int I_DR = 0;
    localparam int I_D  = 1;
    localparam int I_DL = 2;
    localparam int I_R  = MAX_COLS;
    localparam int I_C  = MAX_COLS + 1;
    localparam int I_L  = MAX_COLS + 2;
    localparam int I_UR = 2 * MAX_COLS;
    localparam int I_U  = 2 * MAX_COLS + 1;
    localparam int I_UL = 2 * MAX_COLS + 2;

    logic [LB-1:0] w_lab [NC+1];
    t_tag          w_tag [NC+1];

    assign w_lab[0] = i_lab;
    assign w_tag[0] = i_tag;

    for (genvar k = 0; k < NC; k++) begin : g_cell
        gwdt_cell #(.LB(LB)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_clr   (i_clr),
            .i_shift (i_shift),
            .i_lab   (w_lab[k]),
            .i_tag   (w_tag[k]),
            .o_lab   (w_lab[k+1]),
            .o_tag   (w_tag[k+1])
        );
    end

    function automatic logic f_match(input logic [LB-1:0] lab, input t_tag tag,
                                     input logic [LEVEL_W-1:0] lvl);
        return tag.ins && ({{LEVEL_W{1'b0}}, lab} == {{LB{1'b0}}, lvl});
    endfunction

    t_tag w_ctag;
    logic w_zero;
    logic w_hit;
    logic w_left;
    logic w_right;

    always_comb begin
        w_ctag  = w_tag[I_C+1];
        w_zero  = w_ctag.ins && (w_lab[I_C+1] == '0);
        w_left  = !w_ctag.first;
        w_right = !w_ctag.last;
        w_hit   = f_match(w_lab[I_D+1], w_tag[I_D+1], i_level)
                | f_match(w_lab[I_U+1], w_tag[I_U+1], i_level)
                | (w_left  && f_match(w_lab[I_L+1], w_tag[I_L+1], i_level))
                | (w_right && f_match(w_lab[I_R+1], w_tag[I_R+1], i_level));
        if (i_metric) begin
            // Diagonals for the chessboard metric.
            w_hit = w_hit
                | (w_left  && f_match(w_lab[I_DL+1], w_tag[I_DL+1], i_level))
                | (w_left  && f_match(w_lab[I_UL+1], w_tag[I_UL+1], i_level))
                | (w_right && f_match(w_lab[I_DR+1], w_tag[I_DR+1], i_level))
                | (w_right && f_match(w_lab[I_UR+1], w_tag[I_UR+1], i_level));
        end
        o_cen.real_cell = w_ctag.real_cell;
        o_cen.fill      = w_zero && w_hit;
        o_cen.empty     = w_zero && !w_hit;
    end
endmodule

/* rtl/core/grid_wavefront_distance_transform.sv */
// A write or unused-mode beat gives its result from the result register; a read
// goes through the store read register and then the result register. A run does
// one or more passes; each pass streams (rows+1)*MAX_COLS+1 elements from the
// cell store through the window chain, then drains the r_v1 and r_v2 stages.
// One item is in work at a time; a new beat is taken only when the result
// register is empty or is emptied at the same edge.
// Reset (synchronous, active low) resets control and config, not store or data.
`include "grid_wavefront_distance_transform_macros.svh"
module grid_wavefront_distance_transform #(
    parameter int MAX_ROWS   = 64,
    parameter int MAX_COLS   = 64,
    parameter int LABEL_BITS = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    gwdt_in_if.sink                          i_in,
    gwdt_out_if.source                       o_out,
    input  logic                             i_cfg_we,
    input  logic [gwdt_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [gwdt_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import gwdt_pkg::*;

    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CW    = $clog2(MAX_COLS);
    localparam int AW    = RW + CW;
    localparam int DEPTH = 2 ** AW;
    localparam int EW    = AW + 1;
    localparam int RCW   = RW + 1;       // row counter, holds rows+1
    localparam int CCW   = CW + 1;       // column count, holds MAX_COLS
    localparam int LMAX  = (1 << LABEL_BITS) - 1;
    localparam logic [LABEL_BITS-1:0] NEXT_FIRST = LABEL_BITS'(2);

    // Configuration registers.
    logic                  r_metric;
    logic [LEVEL_W-1:0]    r_limit;
    logic [GRID_DIM_W-1:0] r_grid_rows;
    logic [GRID_DIM_W-1:0] r_grid_cols;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_metric    <= 1'b0;
            r_limit     <= LEVEL_W'(255);
            r_grid_rows <= GRID_DIM_W'(64);
            r_grid_cols <= GRID_DIM_W'(64);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_METRIC: r_metric    <= i_cfg_data[0];
                CFG_LIMIT:  r_limit     <= i_cfg_data;
                CFG_ROWS:   r_grid_rows <= i_cfg_data[GRID_DIM_W-1:0];
                CFG_COLS:   r_grid_cols <= i_cfg_data[GRID_DIM_W-1:0];
                default:    ;
            endcase
        end
    end

    // Control and datapath registers.
    t_state                r_state, n_state;
    logic                  r_ovld;
    logic [LABEL_W-1:0]    r_o_label;
    logic [EMPTY_W-1:0]    r_o_empty;
    logic [RCW-1:0]        r_rows;
    logic [CCW-1:0]        r_cols;
    logic [RCW-1:0]        r_sr;
    logic [CW-1:0]         r_sc;
    logic [RW-1:0]         r_wr_r;
    logic [CW-1:0]         r_wr_c;
    logic [EW-1:0]         r_empty;
    logic [LEVEL_W-1:0]    r_level;
    logic [LABEL_BITS-1:0] r_next;
    logic                  r_v1;
    logic                  r_v2;
    t_tag                  r_tag1;
    logic                  r_rd_in;
    logic [LABEL_BITS-1:0] r_rd_data;
    logic [LABEL_BITS-1:0] r_mem [DEPTH];

    logic                  w_acc;
    logic                  w_run_acc;
    logic                  w_pop;
    logic                  w_in_grid;
    logic [AW-1:0]         w_item_addr;
    logic                  w_emit;
    logic                  w_last_emit;
    t_tag                  w_tag_e;
    logic                  w_re;
    logic [AW-1:0]         w_raddr;
    logic                  w_we;
    logic [AW-1:0]         w_waddr;
    logic [LABEL_BITS-1:0] w_wdata;
    logic                  w_clr;
    logic                  w_drained;
    logic                  w_finish;
    logic [LEVEL_W:0]      w_lvl_inc;
    logic [LEVEL_W:0]      w_lvl_inc2;
    logic [LABEL_BITS-1:0] w_next_after;
    logic [RCW-1:0]        w_rows_c;
    logic [CCW-1:0]        w_cols_c;
    t_cen                  w_cen;

    // Take a beat only when idle and the result register is free or being taken.
    assign w_pop       = r_ovld && o_out.ready;
    assign i_in.ready  = (r_state == S_IDLE) && (!r_ovld || o_out.ready);
    assign w_acc       = i_in.valid && i_in.ready;
    assign w_run_acc   = w_acc && (i_in.mode == MODE_RUN);
    assign w_in_grid   = (32'(i_in.row) < MAX_ROWS) && (32'(i_in.col) < MAX_COLS);
    assign w_item_addr = {RW'(i_in.row), CW'(i_in.col)};

    assign o_out.valid      = r_ovld;
    assign o_out.cell_label = r_o_label;
    assign o_out.empty_left = r_o_empty;

    // Grid size in use, clamped into 2..MAX.
    always_comb begin
        if (r_grid_rows < GRID_DIM_W'(2)) begin
            w_rows_c = RCW'(2);
        end else if (32'(r_grid_rows) > MAX_ROWS) begin
            w_rows_c = RCW'(MAX_ROWS);
        end else begin
            w_rows_c = RCW'(r_grid_rows);
        end
        if (r_grid_cols < GRID_DIM_W'(2)) begin
            w_cols_c = CCW'(2);
        end else if (32'(r_grid_cols) > MAX_COLS) begin
            w_cols_c = CCW'(MAX_COLS);
        end else begin
            w_cols_c = CCW'(r_grid_cols);
        end
    end

    // Stream raster order over the full store stride, then one padding row
    // and one more element so the last real cell reaches the window center.
    assign w_emit            = (r_state == S_RUN);
    assign w_last_emit       = w_emit && (r_sr == r_rows + RCW'(1)) && (r_sc == '0);
    assign w_tag_e.real_cell = (r_sr < r_rows);
    assign w_tag_e.ins       = (r_sr < r_rows) && (CCW'(r_sc) < r_cols);
    assign w_tag_e.first     = (r_sc == '0);
    assign w_tag_e.last      = (CCW'(r_sc) == r_cols - CCW'(1));

    // Level bookkeeping; the new label saturates at the label maximum.
    assign w_lvl_inc  = {1'b0, r_level} + (LEVEL_W+1)'(1);
    assign w_lvl_inc2 = w_lvl_inc + (LEVEL_W+1)'(1);
    always_comb begin
        if (32'(w_lvl_inc2) > LMAX) begin
            w_next_after = LABEL_BITS'(LMAX);
        end else begin
            w_next_after = LABEL_BITS'(w_lvl_inc2);
        end
    end

    assign w_drained = (r_state == S_DRAIN) && !r_v1 && !r_v2;
    assign w_finish  = w_drained && ((r_empty == '0) || (w_lvl_inc >= {1'b0, r_limit}));
    assign w_clr     = w_run_acc || (w_drained && !w_finish);

    // Store ports: item access while idle, pass traffic while running.
    assign w_re    = (w_acc && (i_in.mode == MODE_READ)) || (w_emit && w_tag_e.real_cell);
    assign w_raddr = w_emit ? {r_sr[RW-1:0], r_sc} : w_item_addr;
    assign w_we    = (w_acc && (i_in.mode == MODE_WRITE) && w_in_grid)
                   || (r_v2 && w_cen.fill);
    assign w_waddr = r_v2 ? {r_wr_r, r_wr_c} : w_item_addr;
    assign w_wdata = r_v2 ? r_next : LABEL_BITS'(i_in.cell_value);

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rd_data <= r_mem[w_raddr];
        end
    end

    gwdt_chain #(.MAX_COLS(MAX_COLS), .LB(LABEL_BITS)) u_chain (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clr    (w_clr),
        .i_shift  (r_v1),
        .i_lab    (r_rd_data),
        .i_tag    (r_tag1),
        .i_level  (r_level),
        .i_metric (r_metric),
        .o_cen    (w_cen)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_run_acc) begin
                    n_state = S_RUN;
                end else if (w_acc && (i_in.mode == MODE_READ)) begin
                    n_state = S_READ;
                end
            end
            S_READ:  n_state = S_IDLE;
            S_RUN:   n_state = w_last_emit ? S_DRAIN : S_RUN;
            S_DRAIN: begin
                if (w_finish) begin
                    n_state = S_IDLE;
                end else if (w_drained) begin
                    n_state = S_RUN;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_tag1 <= w_tag_e;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovld  <= 1'b0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_level <= LEVEL_W'(1);
            r_empty <= '0;
        end else begin
            r_state <= n_state;
            r_v1    <= w_emit;
            r_v2    <= r_v1;
            if (w_pop) begin
                r_ovld <= 1'b0;
            end
            // Retire the window center: advance the write pointer, count holes.
            if (r_v2) begin
                if (w_cen.real_cell) begin
                    if (r_wr_c == CW'(MAX_COLS - 1)) begin
                        r_wr_c <= '0;
                        r_wr_r <= r_wr_r + RW'(1);
                    end else begin
                        r_wr_c <= r_wr_c + CW'(1);
                    end
                end
                if (w_cen.empty) begin
                    r_empty <= r_empty + EW'(1);
                end
            end
            if (w_emit) begin
                if (r_sc == CW'(MAX_COLS - 1)) begin
                    r_sc <= '0;
                    r_sr <= r_sr + RCW'(1);
                end else begin
                    r_sc <= r_sc + CW'(1);
                end
            end
            if (w_acc) begin
                case (i_in.mode)
                    MODE_RUN: begin
                        r_rows  <= w_rows_c;
                        r_cols  <= w_cols_c;
                        r_level <= LEVEL_W'(1);
                        r_next  <= NEXT_FIRST;
                        r_sr    <= '0;
                        r_sc    <= '0;
                        r_wr_r  <= '0;
                        r_wr_c  <= '0;
                        r_empty <= '0;
                    end
                    MODE_READ: begin
                        r_rd_in <= w_in_grid;
                    end
                    default: begin
                        // Write and unused mode answer at once with zeros.
                        r_ovld    <= 1'b1;
                        r_o_label <= '0;
                        r_o_empty <= '0;
                    end
                endcase
            end
            if (r_state == S_READ) begin
                r_ovld    <= 1'b1;
                r_o_label <= r_rd_in ? LABEL_W'(r_rd_data) : '0;
                r_o_empty <= '0;
            end
            if (w_drained) begin
                r_level <= LEVEL_W'(w_lvl_inc);
                if (w_finish) begin
                    r_ovld    <= 1'b1;
                    r_o_label <= '0;
                    r_o_empty <= EMPTY_W'(r_empty);
                end else begin
                    // Start the next pass from a clean window.
                    r_next  <= w_next_after;
                    r_sr    <= '0;
                    r_sc    <= '0;
                    r_wr_r  <= '0;
                    r_wr_c  <= '0;
                    r_empty <= '0;
                end
            end
        end
    end

    // Checks on pass sequencing.
    `GWDT_ASSERT_IMP(a_v2_follows_v1, i_clk, i_rst_n, r_v2, $past(r_v1))
    `GWDT_ASSERT_NXT(a_run_starts, i_clk, i_rst_n, w_run_acc, (r_state == S_RUN) && !r_v1)
    `GWDT_ASSERT_NXT(a_drain_exit, i_clk, i_rst_n, w_drained, r_ovld || (r_state == S_RUN))
    `GWDT_ASSERT_IMP(a_fill_in_pass, i_clk, i_rst_n, r_v2 && w_cen.fill, (r_state == S_RUN) || (r_state == S_DRAIN))
endmodule
